/* design/rse_pkg.sv */
`default_nettype none

package rse_pkg;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int DEPTH_W = 5;
  localparam int STAT_W  = 3;

  // default sizing
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    REQ_NUM  = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4,
    REQ_STOP = 3'd5
  } req_kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_UNDER = 3'd1,
    STAT_OVER  = 3'd2,
    STAT_DIVZ  = 3'd3,
    STAT_SAT   = 3'd4
  } stat_t;

  // what the finishing cycle does to the stack
  typedef enum logic [1:0] {
    ACT_REJECT,
    ACT_PUSH,
    ACT_BINOP,
    ACT_STOP
  } act_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPERAND,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load_req;
    logic  mem_rd;
    logic  exec;
    logic  div_start;
    logic  mul_fin;
    logic  div_fin;
    logic  commit;
    act_t  act;
    stat_t fault;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sp_zero;
    logic              sp_lt2;
    logic              sp_full;
    logic              div_skip;
    logic              div_done;
    logic              out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/rse_div.sv */
`default_nettype none

module rse_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rse_pkg::DATA_W-1:0]   dividend_hi,
  input  logic [rse_pkg::DATA_W-1:0]   dividend_lo,
  input  logic [rse_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [rse_pkg::DATA_W-1:0]   quotient
);

  localparam int DW    = rse_pkg::DATA_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [DW-1:0]    den;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DW:0] rem_shift;
  logic [DW:0] rem_diff;
  logic        take;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem, quo[DW-1]};
    rem_diff  = rem_shift - {1'b0, den};
    take      = (rem_shift >= {1'b0, den});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend_hi;
      quo <= dividend_lo;
      den <= divisor;
    end else if (busy) begin
      rem <= take ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
      quo <= {quo[DW-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* design/rse_ctrl.sv */
`default_nettype none

module rse_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rse_pkg::dp_stat_t     dstat,
  output rse_pkg::ctrl_cmd_t    cmd
);

  rse_pkg::state_t state, state_next;
  rse_pkg::act_t   act, act_next;
  rse_pkg::stat_t  fault, fault_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rse_pkg::S_IDLE;
      act   <= rse_pkg::ACT_REJECT;
      fault <= rse_pkg::STAT_OK;
    end else begin
      state <= state_next;
      act   <= act_next;
      fault <= fault_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    act_next   = act;
    fault_next = fault;
    cmd        = '0;
    cmd.act    = act;
    cmd.fault  = fault;
    in_stall   = (state != rse_pkg::S_IDLE);

    case (state)
      rse_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = rse_pkg::S_DECODE;
        end
      end

      // check stack bounds, fetch the second operand for operators
      rse_pkg::S_DECODE: begin
        act_next   = rse_pkg::ACT_REJECT;
        fault_next = rse_pkg::STAT_OK;
        state_next = rse_pkg::S_FINISH;
        case (dstat.kind)
          rse_pkg::REQ_NUM: begin
            if (dstat.sp_full) begin
              fault_next = rse_pkg::STAT_OVER;
            end else begin
              act_next = rse_pkg::ACT_PUSH;
            end
          end
          rse_pkg::REQ_ADD, rse_pkg::REQ_SUB, rse_pkg::REQ_MUL, rse_pkg::REQ_DIV: begin
            if (dstat.sp_lt2) begin
              fault_next = rse_pkg::STAT_UNDER;
            end else begin
              cmd.mem_rd = 1'b1;
              act_next   = rse_pkg::ACT_BINOP;
              state_next = rse_pkg::S_OPERAND;
            end
          end
          rse_pkg::REQ_STOP: begin
            if (dstat.sp_zero) begin
              fault_next = rse_pkg::STAT_UNDER;
            end else begin
              act_next = rse_pkg::ACT_STOP;
            end
          end
          default: ;
        endcase
      end

      // both operands present: run the arithmetic
      rse_pkg::S_OPERAND: begin
        cmd.exec   = 1'b1;
        state_next = rse_pkg::S_FINISH;
        case (dstat.kind)
          rse_pkg::REQ_MUL: begin
            state_next = rse_pkg::S_MUL;
          end
          rse_pkg::REQ_DIV: begin
            if (!dstat.div_skip) begin
              cmd.div_start = 1'b1;
              state_next    = rse_pkg::S_DIV;
            end
          end
          default: ;
        endcase
      end

      rse_pkg::S_MUL: begin
        cmd.mul_fin = 1'b1;
        state_next  = rse_pkg::S_FINISH;
      end

      rse_pkg::S_DIV: begin
        if (dstat.div_done) begin
          cmd.div_fin = 1'b1;
          state_next  = rse_pkg::S_FINISH;
        end
      end

      // update the stack once the output register is free
      rse_pkg::S_FINISH: begin
        if (dstat.out_free) begin
          cmd.commit = 1'b1;
          state_next = rse_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/rse_dpath.sv */
`default_nettype none

module rse_dpath #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rse_pkg::KIND_W-1:0]          req_type,
  input  logic signed [rse_pkg::DATA_W-1:0]   operand_value,
  input  rse_pkg::ctrl_cmd_t                  cmd,
  output rse_pkg::dp_stat_t                   dstat,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [rse_pkg::DATA_W-1:0]   top_value,
  output logic [rse_pkg::DEPTH_W-1:0]         stack_depth,
  output logic [rse_pkg::STAT_W-1:0]          status,
  output logic                                answer_valid
);

  localparam int DW    = rse_pkg::DATA_W;
  localparam int PW    = 2 * DW;
  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int OD_W  = rse_pkg::DEPTH_W;

  // request and stack state
  logic [rse_pkg::KIND_W-1:0] kind;
  logic signed [DW-1:0]       val;
  logic [PTR_W-1:0]           sp;
  logic signed [DW-1:0]       tos;
  logic [DW-1:0]              mem [STACK_DEPTH];
  logic signed [DW-1:0]       rd_data;

  // arithmetic results
  logic signed [DW-1:0] res;
  rse_pkg::stat_t       res_stat;
  logic signed [PW-1:0] prod;

  // output register
  logic signed [DW-1:0] out_top;
  logic [OD_W-1:0]      out_depth;
  rse_pkg::stat_t       out_stat;
  logic                 out_ans;

  logic [PTR_W-1:0]       sp_m1;
  logic [PTR_W-1:0]       sp_m2;
  logic signed [DW-1:0]   opa;
  logic signed [DW-1:0]   opb;
  logic signed [DW:0]     addsub;
  logic                   addsub_ovf;
  logic [DW-1:0]          mag_a;
  logic [DW-1:0]          mag_b;
  logic [PW-1:0]          num;
  logic                   b_zero;
  logic                   div_ovf;
  logic                   div_neg;
  logic signed [PW-1:0]   mul_shift;
  logic                   mul_ovf;
  logic [DW-1:0]          quot;
  logic                   div_done;
  logic [PTR_W-1:0]       sp_after;
  logic signed [DW-1:0]   top_after;
  rse_pkg::stat_t         stat_after;
  logic [PTR_W+OD_W-1:0]  depth_ext;

  // operand a comes from memory, b is the cached top of stack
  always_comb begin
    sp_m1      = sp - PTR_W'(1);
    sp_m2      = sp - PTR_W'(2);
    opa        = rd_data;
    opb        = tos;
    addsub     = (kind == rse_pkg::REQ_SUB) ? ({opa[DW-1], opa} - {opb[DW-1], opb})
                                            : ({opa[DW-1], opa} + {opb[DW-1], opb});
    addsub_ovf = (addsub[DW] != addsub[DW-1]);
    mag_a      = opa[DW-1] ? (~opa + DW'(1)) : opa;
    mag_b      = opb[DW-1] ? (~opb + DW'(1)) : opb;
    num        = {{DW{1'b0}}, mag_a} << FRAC_BITS;
    b_zero     = (opb == '0);
    div_ovf    = (num[PW-1:DW] >= mag_b);
    div_neg    = opa[DW-1] ^ opb[DW-1];
    mul_shift  = prod >>> FRAC_BITS;
    mul_ovf    = !((&mul_shift[PW-1:DW-1]) || !(|mul_shift[PW-1:DW-1]));
  end

  rse_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .dividend_hi (num[PW-1:DW]),
    .dividend_lo (num[DW-1:0]),
    .divisor     (mag_b),
    .done        (div_done),
    .quotient    (quot)
  );

  // status toward the controller
  always_comb begin
    dstat.kind     = kind;
    dstat.sp_zero  = (sp == '0);
    dstat.sp_lt2   = (sp < PTR_W'(2));
    dstat.sp_full  = (sp == PTR_W'(STACK_DEPTH));
    dstat.div_skip = b_zero || div_ovf;
    dstat.div_done = div_done;
    dstat.out_free = !out_valid || !out_stall;
  end

  // stack after this item and the result it reports
  always_comb begin
    sp_after   = sp;
    top_after  = dstat.sp_zero ? '0 : tos;
    stat_after = cmd.fault;
    case (cmd.act)
      rse_pkg::ACT_PUSH: begin
        sp_after   = sp + PTR_W'(1);
        top_after  = val;
        stat_after = rse_pkg::STAT_OK;
      end
      rse_pkg::ACT_BINOP: begin
        sp_after   = sp_m1;
        top_after  = res;
        stat_after = res_stat;
      end
      rse_pkg::ACT_STOP: begin
        sp_after   = '0;
        top_after  = tos;
        stat_after = rse_pkg::STAT_OK;
      end
      default: ;
    endcase
    depth_ext = {{OD_W{1'b0}}, sp_after};
  end

  // request latch, operand fetch and stack storage
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind <= req_type;
      val  <= operand_value;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[sp_m2[IDX_W-1:0]];
    end
    if (cmd.commit && (cmd.act == rse_pkg::ACT_PUSH) && !dstat.sp_zero) begin
      mem[sp_m1[IDX_W-1:0]] <= tos;
    end
    if (cmd.commit && (cmd.act == rse_pkg::ACT_PUSH)) begin
      tos <= val;
    end else if (cmd.commit && (cmd.act == rse_pkg::ACT_BINOP)) begin
      tos <= res;
    end
  end

  // arithmetic
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (kind)
        rse_pkg::REQ_ADD, rse_pkg::REQ_SUB: begin
          if (addsub_ovf) begin
            res      <= addsub[DW] ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX;
            res_stat <= rse_pkg::STAT_SAT;
          end else begin
            res      <= addsub[DW-1:0];
            res_stat <= rse_pkg::STAT_OK;
          end
        end
        rse_pkg::REQ_MUL: begin
          prod <= opa * opb;
        end
        rse_pkg::REQ_DIV: begin
          if (b_zero) begin
            res      <= opa[DW-1] ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX;
            res_stat <= rse_pkg::STAT_DIVZ;
          end else if (div_ovf) begin
            res      <= div_neg ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX;
            res_stat <= rse_pkg::STAT_SAT;
          end
        end
        default: ;
      endcase
    end
    // floor shift of the product is done above, clamp here
    if (cmd.mul_fin) begin
      if (mul_ovf) begin
        res      <= mul_shift[PW-1] ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX;
        res_stat <= rse_pkg::STAT_SAT;
      end else begin
        res      <= mul_shift[DW-1:0];
        res_stat <= rse_pkg::STAT_OK;
      end
    end
    // apply sign to the quotient magnitude
    if (cmd.div_fin) begin
      if (div_neg) begin
        if (quot > rse_pkg::SAT_MIN) begin
          res      <= rse_pkg::SAT_MIN;
          res_stat <= rse_pkg::STAT_SAT;
        end else begin
          res      <= ~quot + DW'(1);
          res_stat <= rse_pkg::STAT_OK;
        end
      end else begin
        if (quot[DW-1]) begin
          res      <= rse_pkg::SAT_MAX;
          res_stat <= rse_pkg::STAT_SAT;
        end else begin
          res      <= quot;
          res_stat <= rse_pkg::STAT_OK;
        end
      end
    end
  end

  // stack pointer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        sp        <= sp_after;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_top   <= top_after;
      out_depth <= depth_ext[OD_W-1:0];
      out_stat  <= stat_after;
      out_ans   <= (cmd.act == rse_pkg::ACT_STOP);
    end
  end

  assign top_value    = out_top;
  assign stack_depth  = out_depth;
  assign status       = out_stat;
  assign answer_valid = out_ans;

endmodule

`default_nettype wire

/* design/rpn_stack_evaluator_unit.sv */
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_stall    req_type, operand_value
// out      output     out_valid / out_stall  top_value, stack_depth, status, answer_valid
//
// one item at a time: number, stop and rejected tokens go through decode and finish;
// add and subtract also through operand, multiply through operand and mul, divide through
// operand and, unless skipped, the bit-serial divider (one quotient bit per cycle).
// the operand below the top is read from the stack memory into a register.
// reset empties the stack and drops any pending result.
// a stalled result holds the next item in its finishing cycle until the output frees.

module rpn_stack_evaluator_unit #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rse_pkg::KIND_W-1:0]          req_type,
  input  logic signed [rse_pkg::DATA_W-1:0]   operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rse_pkg::DATA_W-1:0]   top_value,
  output logic [rse_pkg::DEPTH_W-1:0]         stack_depth,
  output logic [rse_pkg::STAT_W-1:0]          status,
  output logic                                answer_valid
);

  rse_pkg::ctrl_cmd_t cmd;
  rse_pkg::dp_stat_t  dstat;

  // sequencing
  rse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dstat    (dstat),
    .cmd      (cmd)
  );

  // stack, arithmetic and output register
  rse_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .operand_value (operand_value),
    .cmd           (cmd),
    .dstat         (dstat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .status        (status),
    .answer_valid  (answer_valid)
  );

endmodule

`default_nettype wire

/* design/rse_checker.sv */
`default_nettype none

module rse_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [rse_pkg::DATA_W-1:0]   top_value,
  input logic [rse_pkg::DEPTH_W-1:0]         stack_depth,
  input logic [rse_pkg::STAT_W-1:0]          status,
  input logic                                answer_valid
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(top_value) && $stable(stack_depth)
                               && $stable(status) && $stable(answer_valid))
    else $error("stalled result changed");

  // one item in flight: the cycle after an accept is busy
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // an answer empties the stack
  a_answer_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && answer_valid |-> stack_depth == '0 && status == rse_pkg::STAT_OK)
    else $error("answer with non-empty stack or bad status");

  // underflow only on a shallow stack and never with an answer
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rse_pkg::STAT_UNDER |-> stack_depth <= 5'd1 && !answer_valid)
    else $error("underflow reported on a deep stack");

  // reset leaves the block ready with nothing pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state after reset");

endmodule

bind rpn_stack_evaluator_unit rse_checker u_rse_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .top_value    (top_value),
  .stack_depth  (stack_depth),
  .status       (status),
  .answer_valid (answer_valid)
);

`default_nettype wire
